[src/ldrp_pkg.sv]
// ----------------------------------------------------------------------------
// ldrp_pkg
// shared types and constants of the led dimmer ramp pwm channel
// ----------------------------------------------------------------------------
package ldrp_pkg;

	// per mille full scale
	localparam logic [9:0] FULL_SCALE = 10'd1000;

	// shared divider widths
	localparam int NUM_W = 26;
	localparam int DEN_W = 18;
	localparam int CNT_W = $clog2(NUM_W);

	// on-time over full scale: drop three bits, then multiply by 2^30/125 rounded up
	localparam logic [23:0] OT_RECIP = 24'd8589935;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_RISE_TIME,
		REG_FALL_TIME,
		REG_KNEE1_DUTY,
		REG_KNEE1_POINT,
		REG_KNEE2_DUTY,
		REG_KNEE2_POINT,
		REG_PWM_PERIOD,
		REG_DIMMER_ENABLE
	} cfg_idx_t;

	// input request payload
	typedef struct packed {
		logic action;
		logic on_command;
	} in_t;

	// result payload
	typedef struct packed {
		logic [9:0]  duty_permille;
		logic [15:0] on_time;
	} out_t;

	// divider request and response
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

[src/ldrp_mul.sv]
// ----------------------------------------------------------------------------
// ldrp_mul
// shared 16 x 10 multiplier with registered product
// ----------------------------------------------------------------------------
module ldrp_mul
	import ldrp_pkg::*;
(
	input  logic             clk,
	input  logic [15:0]      a,
	input  logic [9:0]       b,
	output logic [NUM_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= NUM_W'(a * b);
	end

endmodule

[src/ldrp_div.sv]
// ----------------------------------------------------------------------------
// ldrp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ldrp_div
	import ldrp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// shift in next numerator bit and try the subtract
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

[src/led_dimmer_ramp_pwm.sv]
// ----------------------------------------------------------------------------
// led_dimmer_ramp_pwm
// one led dimmer channel: ramped pwm duty from on/off commands and ticks
// ----------------------------------------------------------------------------
// sequence: a command takes effect at its accepting edge; a tick of an armed
//   channel steps from S_SEL to S_OUT, with zero to two passes through the
//   shared divider (curve step, fall rescale)
// throughput: commands back to back, ticks one at a time; in_stall
//   stays high while a tick is at work or its result waits on out_stall
// reset: arst_n clears all registers of this module, duty, target and armed flag to zero
// ----------------------------------------------------------------------------
module led_dimmer_ramp_pwm
	import ldrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_idx_t    cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEL,
		S_MULD,
		S_CSTART,
		S_CDIV,
		S_FALL,
		S_FSTART,
		S_FDIV,
		S_UPD,
		S_OT,
		S_OQUO,
		S_OUT
	} state_t;

	// configuration registers
	logic [7:0]  rise_q;
	logic [7:0]  fall_q;
	logic [9:0]  d1_q;
	logic [9:0]  pt1_q;
	logic [9:0]  d2_q;
	logic [9:0]  pt2_q;
	logic [15:0] period_q;
	logic        enable_q;

	// channel state
	state_t      state_q;
	logic [9:0]  duty_q;
	logic        target_q;
	logic        armed_q;
	logic [9:0]  step_q;
	logic [9:0]  den_part_q;
	logic [NUM_W-1:0] num_q;
	logic [15:0] ot_q;
	out_t        out_q;
	logic        out_valid_q;

	// shared units
	logic [15:0]      mul_a;
	logic [9:0]       mul_b;
	logic [NUM_W-1:0] mul_p;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	// on-time reciprocal product
	logic [45:0] ot_prod;

	// curve segment selection
	logic [9:0]  seg_num;
	logic [9:0]  seg_den;
	logic        seg_force;
	logic [10:0] duty_sum;
	logic [9:0]  duty_next;
	logic        accept;

	function automatic logic [9:0] sat_step(input logic [NUM_W-1:0] q);
		sat_step = (q > NUM_W'(FULL_SCALE)) ? FULL_SCALE : q[9:0];
	endfunction

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// register writes; the sender keeps them to idle periods
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q   <= '0;
			fall_q   <= '0;
			d1_q     <= '0;
			pt1_q    <= '0;
			d2_q     <= '0;
			pt2_q    <= '0;
			period_q <= '0;
			enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RISE_TIME:     rise_q   <= cfg_data[7:0];
				REG_FALL_TIME:     fall_q   <= cfg_data[7:0];
				REG_KNEE1_DUTY:    d1_q     <= cfg_data[9:0];
				REG_KNEE1_POINT:   pt1_q    <= cfg_data[9:0];
				REG_KNEE2_DUTY:    d2_q     <= cfg_data[9:0];
				REG_KNEE2_POINT:   pt2_q    <= cfg_data[9:0];
				REG_PWM_PERIOD:    period_q <= cfg_data;
				REG_DIMMER_ENABLE: enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pick the curve segment from the present duty
	always_comb begin
		seg_force = 1'b0;
		if (duty_q <= d1_q) begin
			seg_num = d1_q;
			seg_den = pt1_q;
		end else if (duty_q <= d2_q) begin
			seg_num = d2_q - d1_q;
			seg_den = pt2_q - pt1_q;
			if (pt2_q <= pt1_q)
				seg_force = 1'b1;
		end else begin
			seg_num = FULL_SCALE - d2_q;
			seg_den = FULL_SCALE - pt2_q;
			if (pt2_q >= FULL_SCALE || d2_q >= FULL_SCALE)
				seg_force = 1'b1;
		end
		// zero divisor gives full step
		if (seg_den == '0 || rise_q == '0)
			seg_force = 1'b1;
	end

	// ramp toward the target with saturation at both ends
	always_comb begin
		duty_sum = {1'b0, duty_q} + {1'b0, step_q};
		if (target_q)
			duty_next = (duty_sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : duty_sum[9:0];
		else
			duty_next = (duty_q >= step_q) ? duty_q - step_q : '0;
	end

	// multiplier operands per sequencer step
	always_comb begin
		case (state_q)
			S_SEL: begin
				mul_a = {6'd0, seg_num};
				mul_b = FULL_SCALE;
			end
			S_MULD: begin
				mul_a = {6'd0, den_part_q};
				mul_b = {2'd0, rise_q};
			end
			S_FALL: begin
				mul_a = {6'd0, step_q};
				mul_b = {2'd0, rise_q};
			end
			S_OT: begin
				mul_a = period_q;
				mul_b = duty_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divider requests: curve step and fall rescale
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = mul_p;
		div_req.den   = '0;
		case (state_q)
			S_CSTART: begin
				div_req.start = 1'b1;
				div_req.num   = num_q;
				div_req.den   = mul_p[DEN_W-1:0];
			end
			S_FSTART: begin
				div_req.start = 1'b1;
				div_req.den   = {10'd0, fall_q};
			end
			default: ;
		endcase
	end

	// period*duty/1000 as (period*duty/8)/125 by reciprocal, exact below 2^26
	assign ot_prod = {23'd0, mul_p[NUM_W-1:3]} * {22'd0, OT_RECIP};

	ldrp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	ldrp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer with channel state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			duty_q      <= '0;
			target_q    <= 1'b0;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			den_part_q  <= '0;
			num_q       <= '0;
			ot_q        <= '0;
			out_q       <= '0;
		end else begin
			// result taken downstream
			if (out_valid_q && !out_stall && state_q != S_OUT)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!in_data.action) begin
							// command: set target and arm; with the dimmer disabled, duty jumps to the target
							target_q <= in_data.on_command;
							armed_q  <= 1'b1;
							if (!enable_q)
								duty_q <= in_data.on_command ? FULL_SCALE : '0;
						end else if (armed_q) begin
							state_q <= S_SEL;
						end
					end
				end
				S_SEL: begin
					den_part_q <= seg_den;
					if (seg_force) begin
						step_q  <= FULL_SCALE;
						state_q <= S_FALL;
					end else begin
						state_q <= S_MULD;
					end
				end
				S_MULD: begin
					num_q   <= mul_p;
					state_q <= S_CSTART;
				end
				S_CSTART: state_q <= S_CDIV;
				S_CDIV: begin
					if (div_rsp.done) begin
						step_q  <= sat_step(div_rsp.quo);
						state_q <= S_FALL;
					end
				end
				S_FALL: begin
					// falling: rescale by rise over fall, full step at zero fall time
					if (target_q) begin
						state_q <= S_UPD;
					end else if (fall_q == '0) begin
						step_q  <= FULL_SCALE;
						state_q <= S_UPD;
					end else begin
						state_q <= S_FSTART;
					end
				end
				S_FSTART: state_q <= S_FDIV;
				S_FDIV: begin
					if (div_rsp.done) begin
						step_q  <= sat_step(div_rsp.quo);
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					duty_q  <= duty_next;
					state_q <= S_OT;
				end
				S_OT: state_q <= S_OQUO;
				S_OQUO: begin
					// product of period and duty is in mul_p here
					ot_q    <= ot_prod[45:30];
					state_q <= S_OUT;
				end
				S_OUT: begin
					// load once the output register is free
					if (!out_valid_q || !out_stall) begin
						out_q.duty_permille <= duty_q;
						out_q.on_time       <= ot_q;
						out_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/ldrp_chk.sv]
// ----------------------------------------------------------------------------
// ldrp_chk
// port-level checks of the led dimmer ramp pwm channel
// ----------------------------------------------------------------------------
module ldrp_chk
	import ldrp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input in_t         in_data,
	input logic        out_valid,
	input logic        out_stall,
	input out_t        out_data
);

	// duty never leaves full scale
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.duty_permille <= FULL_SCALE)
		else $error("duty above full scale");

	// zero duty gives zero on-time
	a_zero_on_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.duty_permille == '0 |-> out_data.on_time == '0)
		else $error("on-time nonzero at zero duty");

	// after a command request the channel is free again in the next cycle
	a_cmd_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !in_data.action |=> !in_stall)
		else $error("channel busy after command");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind led_dimmer_ramp_pwm ldrp_chk u_chk (.*);
